>>> sv/bawc_pkg.sv
// Shared types and constants for the blob autotile window classifier.
// Used by bawc_window, bawc_emit and the top level; no dependencies.
`timescale 1ns / 1ps

package bawc_pkg;

   // frame limits and derived widths
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;
   localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

   // fixed field widths
   localparam int unsigned DIM_W   = 11;
   localparam int unsigned TS_W    = 8;
   localparam int unsigned GRID_W  = 10;
   localparam int unsigned WORLD_W = 18;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned WCOL_W  = 3 * CODE_W;
   localparam int unsigned SLOTS   = 4;

   // input pixel codes
   localparam logic [7:0] TILE_SOLID   = 8'd0;
   localparam logic [7:0] TILE_ITEM    = 8'd1;
   localparam logic [7:0] OPACITY_NONE = 8'd0;
   localparam logic [7:0] OPACITY_FULL = 8'd255;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_TILE_SIZE    = 2'd2
   } reg_index_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_SOLID = 2'd1,
      KIND_ITEM  = 2'd2
   } kind_type;

   // frame geometry from the register block
   typedef struct packed {
      logic [COL_W-1:0] width_last;
      logic [ROW_W-1:0] height_last;
      logic             restart;
   } win_cfg_type;

   // up to four results caused by one input word
   // slot 0: (r-1, c-1), slot 1: (r-1, c), slot 2: (r, c-1), slot 3: (r, c)
   typedef struct packed {
      logic [SLOTS-1:0]            mask;
      kind_type [SLOTS-1:0]        kind;
      logic [SLOTS-1:0][IDX_W-1:0] idx;
      logic [COL_W-1:0]            col;
      logic [ROW_W-1:0]            row;
   } group_type;

endpackage

>>> sv/bawc_window.sv
// Line store, 3x3 window and blob classification for the window classifier.
// Depends on bawc_pkg; feeds result groups to bawc_emit.
`timescale 1ns / 1ps

module bawc_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // tile_code[7:0], opacity[15:8]
   input  bawc_pkg::win_cfg_type cfg,
   output bawc_pkg::group_type grp,
   output logic                grp_valid,
   input  logic                grp_ready
);
   import bawc_pkg::*;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] idx;
   } slot_type;

   // 47-way blob tile decision tree over the eight open flags
   function automatic logic [IDX_W-1:0] blob_index(logic u, logic r, logic d, logic l,
                                                   logic ul, logic ur, logic dl, logic dr);
      logic [IDX_W-1:0] v;
      if (u) begin
         if (r) begin
            if (d)      v = l ? 6'd19 : 6'd22;
            else if (l) v = 6'd36;
            else        v = dl ? 6'd39 : 6'd2;
         end else if (l) begin
            v = d ? 6'd20 : (dr ? 6'd40 : 6'd0);
         end else if (d) begin
            v = 6'd21;
         end else if (dl) begin
            v = dr ? 6'd28 : 6'd27;
         end else begin
            v = dr ? 6'd29 : 6'd1;
         end
      end else if (r) begin
         if (l)       v = d ? 6'd38 : 6'd37;
         else if (d)  v = ul ? 6'd41 : 6'd4;
         else if (ul) v = dl ? 6'd31 : 6'd32;
         else         v = dl ? 6'd30 : 6'd3;
      end else if (d) begin
         if (l)       v = ur ? 6'd42 : 6'd6;
         else if (ul) v = ur ? 6'd34 : 6'd33;
         else         v = ur ? 6'd35 : 6'd5;
      end else if (l) begin
         if (ur) v = dr ? 6'd25 : 6'd24;
         else    v = dr ? 6'd26 : 6'd7;
      end else if (dr) begin
         if (dl) begin
            if (ul) v = ur ? 6'd23 : 6'd43;
            else    v = ur ? 6'd44 : 6'd14;
         end else if (ul) begin
            v = ur ? 6'd45 : 6'd17;
         end else begin
            v = ur ? 6'd15 : 6'd9;
         end
      end else if (dl) begin
         if (ur) v = ul ? 6'd46 : 6'd18;
         else    v = ul ? 6'd13 : 6'd10;
      end else if (ul) begin
         v = ur ? 6'd16 : 6'd11;
      end else begin
         v = ur ? 6'd12 : 6'd8;
      end
      return v;
   endfunction

   // classify one centre pixel; lane2 selects the bottom lane as centre
   function automatic slot_type classify(logic [WCOL_W-1:0] lc, logic [WCOL_W-1:0] cc,
                                         logic [WCOL_W-1:0] rc, logic has_l, logic has_r,
                                         logic has_u, logic has_d, logic lane2);
      slot_type s;
      logic [CODE_W-1:0] centre;
      logic u, r, d, l, ul, ur, dl, dr;
      centre = lane2 ? cc[8:6] : cc[5:3];
      u  = has_u & (lane2 ? cc[3] : cc[0]);
      d  = has_d & (lane2 ? 1'b0 : cc[6]);
      l  = has_l & (lane2 ? lc[6] : lc[3]);
      r  = has_r & (lane2 ? rc[6] : rc[3]);
      ul = has_l & has_u & (lane2 ? lc[3] : lc[0]);
      ur = has_r & has_u & (lane2 ? rc[3] : rc[0]);
      dl = has_l & has_d & (lane2 ? 1'b0 : lc[6]);
      dr = has_r & has_d & (lane2 ? 1'b0 : rc[6]);
      s.kind = KIND_NONE;
      s.idx  = '0;
      if (centre[1]) begin
         s.kind = KIND_SOLID;
         s.idx  = blob_index(u, r, d, l, ul, ur, dl, dr);
      end else if (centre[2]) begin
         s.kind = KIND_ITEM;
      end
      return s;
   endfunction

   // line store: {newer row, older row} per column
   logic [2*CODE_W-1:0] line_mem [MAX_WIDTH];
   logic [2*CODE_W-1:0] rd_ff;

   // input position counters
   logic [COL_W-1:0] c_cnt_ff, c_cnt_in;
   logic [ROW_W-1:0] r_cnt_ff, r_cnt_in;

   // stage B: word whose store read is in flight
   logic                b_valid_ff, b_valid_in;
   logic [CODE_W-1:0]   b_px_ff;
   logic [COL_W-1:0]    b_col_ff;
   logic [ROW_W-1:0]    b_row_ff;
   logic                b_fwd_ff;
   logic [2*CODE_W-1:0] b_fwd_data_ff;

   // three-column window
   logic [2:0][WCOL_W-1:0] win_ff, win_in;

   logic                accept, b_adv, fwd_hit;
   logic [7:0]          code8, op8;
   logic [CODE_W-1:0]   px;
   logic [2*CODE_W-1:0] rd_eff;
   logic [WCOL_W-1:0]   new_col;
   logic                row_end, last_row, c_pos, c_gt1, r_pos, r_gt1;
   slot_type [SLOTS-1:0] slot;

   assign b_adv      = b_valid_ff && grp_ready;
   assign req_tready = !b_valid_ff || grp_ready;
   assign accept     = req_tvalid && req_tready;
   assign fwd_hit    = accept && b_adv && (c_cnt_ff == b_col_ff);

   // pixel code: bit0 open, bit1 solid, bit2 item
   assign code8 = req_tdata[7:0];
   assign op8   = req_tdata[15:8];
   always_comb begin
      px[0] = !((code8 == TILE_SOLID) && (op8 != OPACITY_NONE));
      px[1] = (code8 == TILE_SOLID) && (op8 == OPACITY_FULL);
      px[2] = (code8 == TILE_ITEM) && (op8 == OPACITY_FULL);
   end

   // counters advance in raster order
   always_comb begin
      c_cnt_in = c_cnt_ff;
      r_cnt_in = r_cnt_ff;
      if (cfg.restart) begin
         c_cnt_in = '0;
         r_cnt_in = '0;
      end else if (accept) begin
         if (c_cnt_ff == cfg.width_last) begin
            c_cnt_in = '0;
            r_cnt_in = (r_cnt_ff == cfg.height_last) ? '0 : r_cnt_ff + 1'b1;
         end else begin
            c_cnt_in = c_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept)     b_valid_in = 1'b1;
      else if (b_adv) b_valid_in = 1'b0;
   end

   // store read with forwarding of a write to the same column
   assign rd_eff  = b_fwd_ff ? b_fwd_data_ff : rd_ff;
   assign new_col = {b_px_ff, rd_eff[5:3], rd_eff[2:0]};

   always_comb begin
      win_in = win_ff;
      if (cfg.restart) begin
         win_in = '0;
      end else if (b_adv) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = new_col;
      end
   end

   // result slots for the word in stage B
   assign row_end  = (b_col_ff == cfg.width_last);
   assign last_row = (b_row_ff == cfg.height_last);
   assign c_pos    = (b_col_ff != '0);
   assign c_gt1    = (b_col_ff > COL_W'(1));
   assign r_pos    = (b_row_ff != '0);
   assign r_gt1    = (b_row_ff > ROW_W'(1));

   always_comb begin
      slot[0] = classify(win_ff[1], win_ff[2], new_col, c_gt1, 1'b1, r_gt1, 1'b1, 1'b0);
      slot[1] = classify(win_ff[2], new_col, '0, c_pos, 1'b0, r_gt1, 1'b1, 1'b0);
      slot[2] = classify(win_ff[1], win_ff[2], new_col, c_gt1, 1'b1, r_pos, 1'b0, 1'b1);
      slot[3] = classify(win_ff[2], new_col, '0, c_pos, 1'b0, r_pos, 1'b0, 1'b1);
      grp.mask = {last_row & row_end, last_row & c_pos, r_pos & row_end, r_pos & c_pos};
      for (int i = 0; i < SLOTS; i++) begin
         grp.kind[i] = slot[i].kind;
         grp.idx[i]  = slot[i].idx;
      end
      grp.col = b_col_ff;
      grp.row = b_row_ff;
   end
   assign grp_valid = b_valid_ff;

   // line store port: read on accept, write when stage B retires
   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem[c_cnt_ff];
      if (b_adv)  line_mem[b_col_ff] <= {b_px_ff, rd_eff[5:3]};
   end

   // stage B payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_px_ff       <= px;
         b_col_ff      <= c_cnt_ff;
         b_row_ff      <= r_cnt_ff;
         b_fwd_ff      <= fwd_hit;
         b_fwd_data_ff <= {b_px_ff, rd_eff[5:3]};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         c_cnt_ff   <= '0;
         r_cnt_ff   <= '0;
         b_valid_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         c_cnt_ff   <= c_cnt_in;
         r_cnt_ff   <= r_cnt_in;
         b_valid_ff <= b_valid_in;
         win_ff     <= win_in;
      end
   end

   // a same-column forward only arises with a one-pixel row
   a_fwd_width: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_fwd_ff |-> cfg.width_last == '0)
      else $error("column forward with row wider than one pixel");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      c_cnt_ff <= cfg.width_last)
      else $error("column counter beyond row width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      r_cnt_ff <= cfg.height_last)
      else $error("row counter beyond frame height");

   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !grp_ready |=> b_valid_ff && $stable(b_col_ff) && $stable(b_px_ff))
      else $error("stalled stage B word changed");

endmodule

>>> sv/bawc_emit.sv
// Result serializer and output register for the window classifier.
// Depends on bawc_pkg; takes groups from bawc_window.
`timescale 1ns / 1ps

module bawc_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  bawc_pkg::group_type  grp,
   input  logic                 grp_valid,
   output logic                 grp_ready,
   input  logic [7:0]           world_scale,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // grid_col[9:0], grid_row[19:10], world_x[37:20], world_y[55:38],
   // tile_index[61:56], zero[63:62]
   output logic [63:0]          rsp_tdata,
   output logic                 rsp_tlast,   // run_last
   output logic [2:0]           rsp_tuser    // kind[1:0], frame_last[2]
);
   import bawc_pkg::*;

   // pending group
   group_type        grp_ff;
   logic [SLOTS-1:0] mask_ff, mask_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [GRID_W-1:0]  out_col_ff;
   logic [GRID_W-1:0]  out_row_ff;
   logic [WORLD_W-1:0] out_wx_ff;
   logic [WORLD_W-1:0] out_wy_ff;
   kind_type           out_kind_ff;
   logic [IDX_W-1:0]   out_idx_ff;
   logic               out_run_last_ff;
   logic               out_frame_last_ff;

   logic [1:0]             sel;
   logic [SLOTS-1:0]       low, rest;
   logic                   out_ready, emit, load;
   logic [COL_W-1:0]       col_sel;
   logic [ROW_W-1:0]       row_sel;
   logic [COL_W+TS_W-1:0]  prod_x;
   logic [ROW_W+TS_W-1:0]  prod_y;

   // lowest pending slot goes first
   always_comb begin
      if (mask_ff[0])      sel = 2'd0;
      else if (mask_ff[1]) sel = 2'd1;
      else if (mask_ff[2]) sel = 2'd2;
      else                 sel = 2'd3;
   end
   assign low  = SLOTS'(1) << sel;
   assign rest = mask_ff & ~low;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign emit      = (mask_ff != '0) && out_ready;
   assign grp_ready = (mask_ff == '0) || (out_ready && rest == '0);
   assign load      = grp_valid && grp_ready;

   always_comb begin
      mask_in = mask_ff;
      if (load)      mask_in = grp.mask;
      else if (emit) mask_in = rest;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit)            out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   // position of the selected slot and its world coordinates
   assign col_sel = sel[0] ? grp_ff.col : grp_ff.col - 1'b1;
   assign row_sel = sel[1] ? grp_ff.row : grp_ff.row - 1'b1;
   assign prod_x  = (COL_W+TS_W)'(col_sel) * (COL_W+TS_W)'(world_scale);
   assign prod_y  = (ROW_W+TS_W)'(row_sel) * (ROW_W+TS_W)'(world_scale);

   always_ff @(posedge clock) begin
      if (load) grp_ff <= grp;
      if (emit) begin
         out_col_ff        <= GRID_W'(col_sel);
         out_row_ff        <= GRID_W'(row_sel);
         out_wx_ff         <= WORLD_W'(prod_x);
         out_wy_ff         <= WORLD_W'(prod_y);
         out_kind_ff       <= grp_ff.kind[sel];
         out_idx_ff        <= grp_ff.idx[sel];
         out_run_last_ff   <= (rest == '0);
         out_frame_last_ff <= (sel == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_idx_ff, out_wy_ff, out_wx_ff, out_row_ff, out_col_ff};
   assign rsp_tlast  = out_run_last_ff;
   assign rsp_tuser  = {out_frame_last_ff, out_kind_ff};

   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_frame_last_ff |-> out_run_last_ff)
      else $error("frame end word not the last of its run");

   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != KIND_SOLID |-> out_idx_ff == '0)
      else $error("tile index on a non-solid result");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_SOLID |-> out_idx_ff <= IDX_W'(46))
      else $error("blob index out of range");

endmodule

>>> sv/blob_autotile_window_classifier_unit.sv
// Blob autotile window classifier: one result word per pixel after a row and column of delay.
// First result of a word passes stage B, the pending-group register and the output register.
// Throughput: one input word per cycle unless stalled; a word causing k results holds input until
// the single output register, draining one result word per cycle when ready, has taken all k.
// Reset: synchronous; clears counters, window, pipeline valids and registers to defaults.
// Line store contents are not cleared; rows not yet written are masked off.
`timescale 1ns / 1ps

module blob_autotile_window_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tile_code[7:0], opacity[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // grid_col[9:0], grid_row[19:10], world_x[37:20], world_y[55:38],
   // tile_index[61:56], zero[63:62]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,   // run_last
   output logic [2:0]  rsp_tuser,   // kind[1:0], frame_last[2]
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import bawc_pkg::*;

   // clamp a dimension to 1..maxv and return the last index
   function automatic int unsigned dim_last(logic [DIM_W-1:0] v, int unsigned maxv);
      int unsigned r;
      if (v == '0)                r = 0;
      else if (int'(v) > maxv)    r = maxv - 1;
      else                        r = int'(v) - 1;
      return r;
   endfunction

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [TS_W-1:0]  tsize_ff, tsize_in;
   logic             restart;

   win_cfg_type cfg;
   group_type   grp;
   logic        grp_valid, grp_ready;

   // register writes; any known index restarts the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      tsize_in  = tsize_ff;
      restart   = 1'b0;
      if (csr_wen) begin
         case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            REG_TILE_SIZE: begin
               tsize_in = csr_wdata[TS_W-1:0];
               restart  = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(64);
         height_ff <= DIM_W'(64);
         tsize_ff  <= TS_W'(16);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         tsize_ff  <= tsize_in;
      end
   end

   assign cfg.width_last  = COL_W'(dim_last(width_ff, MAX_WIDTH));
   assign cfg.height_last = ROW_W'(dim_last(height_ff, MAX_HEIGHT));
   assign cfg.restart     = restart;

   bawc_window u_window (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .grp        (grp),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready)
   );

   bawc_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .grp         (grp),
      .grp_valid   (grp_valid),
      .grp_ready   (grp_ready),
      .world_scale (tsize_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

>>> dv/bawc_tb_pkg.sv
// Scoreboard for the blob autotile window classifier: result record and expected-cell predictor.
// Depends on bawc_pkg for field widths, pixel codes, register indexes and result kinds.
`timescale 1ns / 1ps

package bawc_tb_pkg;

   import bawc_pkg::*;

   // bit positions inside a 3-bit pixel code
   localparam int unsigned OPEN_BIT  = 0;
   localparam int unsigned SOLID_BIT = 1;
   localparam int unsigned ITEM_BIT  = 2;

   // cap on printed mismatch lines; all of them are still counted
   localparam int unsigned MAX_REPORTS = 40;

   // one classified map cell as it leaves the block
   typedef struct {
      logic [GRID_W-1:0]  grid_col;
      logic [GRID_W-1:0]  grid_row;
      logic [WORLD_W-1:0] world_x;
      logic [WORLD_W-1:0] world_y;
      kind_type           kind;
      logic [IDX_W-1:0]   tile_index;
      logic               run_last;
      logic               frame_last;
   } cell_result_type;

   class autotile_scoreboard;

      int unsigned errors;

      // register copies
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      logic [TS_W-1:0]  tile_sz;

      // line stores, window and raster position
      logic [CODE_W-1:0] older_codes [MAX_WIDTH];
      logic [CODE_W-1:0] newer_codes [MAX_WIDTH];
      logic [WCOL_W-1:0] win_cols [3];
      int unsigned       col_pos;
      int unsigned       row_pos;

      cell_result_type expected_cells [$];

      function new();
         errors = 0;
         width_reg = 64;
         height_reg = 64;
         tile_sz = 16;
         foreach (older_codes[i]) begin
            older_codes[i] = '0;
            newer_codes[i] = '0;
         end
         restart_frame();
      endfunction

      function void restart_frame();
         foreach (win_cols[i]) win_cols[i] = '0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      function int unsigned pending();
         return expected_cells.size();
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned limit);
         if (v < 1) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      // any register write restarts the frame
      function void write_reg(reg_index_type idx, logic [DIM_W-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH: width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            REG_TILE_SIZE: tile_sz = value[TS_W-1:0];
            default: return;
         endcase
         restart_frame();
      endfunction

      function bit open_at(logic [WCOL_W-1:0] wcol, int lane, bit ok);
         if (!ok || lane > 2) return 1'b0;
         return wcol[CODE_W*lane + OPEN_BIT];
      endfunction

      // 47-way blob tile decision tree over the eight open flags
      function logic [IDX_W-1:0] blob_tile(bit u, bit r, bit d, bit l,
                                           bit ul, bit ur, bit dl, bit dr);
         if (u) begin
            if (r) begin
               if (d) return l ? 19 : 22;
               if (l) return 36;
               return dl ? 39 : 2;
            end
            if (l) return d ? 20 : (dr ? 40 : 0);
            if (d) return 21;
            if (dl) return dr ? 28 : 27;
            return dr ? 29 : 1;
         end
         if (r) begin
            if (l) return d ? 38 : 37;
            if (d) return ul ? 41 : 4;
            if (ul) return dl ? 31 : 32;
            return dl ? 30 : 3;
         end
         if (d) begin
            if (l) return ur ? 42 : 6;
            if (ul) return ur ? 34 : 33;
            return ur ? 35 : 5;
         end
         if (l) begin
            if (ur) return dr ? 25 : 24;
            return dr ? 26 : 7;
         end
         if (dr) begin
            if (dl) begin
               if (ul) return ur ? 23 : 43;
               return ur ? 44 : 14;
            end
            if (ul) return ur ? 45 : 17;
            return ur ? 15 : 9;
         end
         if (dl) begin
            if (ur) return ul ? 46 : 18;
            return ul ? 13 : 10;
         end
         if (ul) return ur ? 16 : 11;
         return ur ? 12 : 8;
      endfunction

      // classify the cell at the given lane of the centre window column
      function cell_result_type make_cell(int unsigned row, int unsigned col,
                                          logic [WCOL_W-1:0] lc, logic [WCOL_W-1:0] cc,
                                          logic [WCOL_W-1:0] rc, bit has_l, bit has_r,
                                          int lane, bit has_u, bit has_d);
         cell_result_type res;
         logic [CODE_W-1:0] centre;
         int up, dn;
         centre = cc[CODE_W*lane +: CODE_W];
         up = lane - 1;
         dn = lane + 1;
         res.kind = KIND_NONE;
         res.tile_index = '0;
         if (centre[SOLID_BIT]) begin
            res.kind = KIND_SOLID;
            res.tile_index = blob_tile(open_at(cc, up, has_u), open_at(rc, lane, has_r),
                                       open_at(cc, dn, has_d), open_at(lc, lane, has_l),
                                       open_at(lc, up, has_l && has_u),
                                       open_at(rc, up, has_r && has_u),
                                       open_at(lc, dn, has_l && has_d),
                                       open_at(rc, dn, has_r && has_d));
         end else if (centre[ITEM_BIT]) begin
            res.kind = KIND_ITEM;
         end
         res.grid_col = GRID_W'(col);
         res.grid_row = GRID_W'(row);
         res.world_x = WORLD_W'(col * tile_sz);
         res.world_y = WORLD_W'(row * tile_sz);
         res.run_last = 1'b0;
         res.frame_last = 1'b0;
         return res;
      endfunction

      // one accepted pixel word: shift the window and queue the cells it completes
      function void note_pixel(logic [7:0] code, logic [7:0] opac);
         int unsigned w, h, c, r, n;
         logic [CODE_W-1:0] px;
         cell_result_type cells [4];
         bit row_end, last_row;
         w = clamp_dim(width_reg, MAX_WIDTH);
         h = clamp_dim(height_reg, MAX_HEIGHT);
         c = (col_pos >= w) ? 0 : col_pos;
         r = (row_pos >= h) ? 0 : row_pos;
         px = '0;
         if (!(code == TILE_SOLID && opac != OPACITY_NONE)) px[OPEN_BIT] = 1'b1;
         if (code == TILE_SOLID && opac == OPACITY_FULL) px[SOLID_BIT] = 1'b1;
         if (code == TILE_ITEM && opac == OPACITY_FULL) px[ITEM_BIT] = 1'b1;

         win_cols[0] = win_cols[1];
         win_cols[1] = win_cols[2];
         win_cols[2] = {px, newer_codes[c], older_codes[c]};
         older_codes[c] = newer_codes[c];
         newer_codes[c] = px;

         row_end = (c == w - 1);
         last_row = (r == h - 1);
         n = 0;
         // row above, middle lane
         if (r >= 1) begin
            if (c >= 1) begin
               cells[n] = make_cell(r - 1, c - 1, win_cols[0], win_cols[1], win_cols[2],
                                    c > 1, 1'b1, 1, r > 1, 1'b1);
               n++;
            end
            if (row_end) begin
               cells[n] = make_cell(r - 1, c, win_cols[1], win_cols[2], '0,
                                    c > 0, 1'b0, 1, r > 1, 1'b1);
               n++;
            end
         end
         // last row comes out interleaved, bottom lane
         if (last_row) begin
            if (c >= 1) begin
               cells[n] = make_cell(r, c - 1, win_cols[0], win_cols[1], win_cols[2],
                                    c > 1, 1'b1, 2, r > 0, 1'b0);
               n++;
            end
            if (row_end) begin
               cells[n] = make_cell(r, c, win_cols[1], win_cols[2], '0,
                                    c > 0, 1'b0, 2, r > 0, 1'b0);
               cells[n].frame_last = 1'b1;
               n++;
            end
         end
         if (n > 0) cells[n-1].run_last = 1'b1;
         for (int i = 0; i < n; i++) expected_cells.push_back(cells[i]);

         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task compare_field(string name, int unsigned got, int unsigned want,
                         cell_result_type res);
         if (got != want)
            report($sformatf("cell (%0d,%0d) %s: got %0d, expected %0d",
                             res.grid_col, res.grid_row, name, got, want));
      endtask

      // one accepted result word against the oldest expected cell
      task check_cell(logic [63:0] data, logic last, logic [2:0] user);
         cell_result_type want;
         if (expected_cells.size() == 0) begin
            report($sformatf("unexpected result word col %0d row %0d",
                             data[9:0], data[19:10]));
            return;
         end
         want = expected_cells.pop_front();
         compare_field("grid_col", data[9:0], want.grid_col, want);
         compare_field("grid_row", data[19:10], want.grid_row, want);
         compare_field("world_x", data[37:20], want.world_x, want);
         compare_field("world_y", data[55:38], want.world_y, want);
         compare_field("tile_index", data[61:56], want.tile_index, want);
         compare_field("pad", data[63:62], 0, want);
         compare_field("kind", user[1:0], int'(want.kind), want);
         compare_field("frame_last", user[2], want.frame_last, want);
         compare_field("run_last", last, want.run_last, want);
      endtask

   endclass

endpackage

>>> dv/tb_top.sv
// Top-level testbench for blob_autotile_window_classifier_unit: clock, reset, stream drivers.
// Depends on bawc_pkg (RTL) and bawc_tb_pkg (scoreboard); directed frames then random frames.
`timescale 1ns / 1ps

module tb_top;

   import bawc_pkg::*;
   import bawc_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 405;

   // pixel words {opacity, tile_code}
   localparam logic [15:0] PX_SOLID    = {OPACITY_FULL, TILE_SOLID};
   localparam logic [15:0] PX_EMPTY    = {OPACITY_NONE, TILE_SOLID};
   localparam logic [15:0] PX_ITEM     = {OPACITY_FULL, TILE_ITEM};
   localparam logic [15:0] PX_INERT    = {8'd128, TILE_SOLID};
   localparam logic [15:0] PX_HIGH     = {8'hFF, 8'hFF};
   localparam logic [15:0] PX_FAINT    = {8'd1, 8'd2};
   localparam logic [15:0] PX_DIM_ITEM = {8'd254, TILE_ITEM};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;

   autotile_scoreboard sb = new();

   int cycle_count = 0;
   bit idle_send = 1'b1;
   bit idle_recv = 1'b1;
   bit hold_request = 1'b0;

   blob_autotile_window_classifier_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_pixel(int solid_pct);
      logic [7:0] code, opac;
      if ($urandom_range(0, 99) < solid_pct) begin
         code = TILE_SOLID;
         opac = OPACITY_FULL;
      end else begin
         case ($urandom_range(0, 5))
            0: begin code = TILE_SOLID; opac = OPACITY_NONE; end
            1: begin code = TILE_ITEM; opac = OPACITY_FULL; end
            2: begin code = TILE_SOLID; opac = 8'($urandom_range(1, 254)); end
            3: begin code = TILE_ITEM; opac = 8'($urandom_range(0, 254)); end
            default: begin code = 8'($urandom); opac = 8'($urandom); end
         endcase
      end
      return {opac, code};
   endfunction

   // all three registers, one per cycle, then the frame restarts
   task automatic write_config(logic [10:0] w, logic [10:0] h, logic [7:0] ts);
      csr_wen <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.write_reg(REG_IMAGE_WIDTH, w);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(REG_IMAGE_HEIGHT, h);
      csr_index <= REG_TILE_SIZE;
      csr_wdata <= {3'b000, ts};
      @(posedge clock);
      sb.write_reg(REG_TILE_SIZE, {3'b000, ts});
      csr_wen <= 1'b0;
   endtask

   task automatic send_pixel(logic [15:0] word);
      int gap;
      gap = pick_gap(idle_send);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(word[7:0], word[15:8]);
   endtask

   // drain every expected word, then give the pipeline time to go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check, then pick the next ready level
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_cell(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left == 0) stall_left = pick_gap(idle_recv);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] frame_pixels [20];
      int unsigned w_set, h_set, ts_set, frame, items, random_count, phase, solid_pct;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_wen <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed 5x4 frame: solids around holes, items, inert and odd codes
      frame_pixels = '{PX_SOLID, PX_SOLID, PX_SOLID, PX_EMPTY, PX_SOLID,
                       PX_SOLID, PX_EMPTY, PX_SOLID, PX_SOLID, PX_ITEM,
                       PX_SOLID, PX_SOLID, PX_INERT, PX_SOLID, PX_SOLID,
                       PX_HIGH, PX_SOLID, PX_SOLID, PX_FAINT, PX_DIM_ITEM};
      write_config(11'd5, 11'd4, 8'd7);
      foreach (frame_pixels[i]) send_pixel(frame_pixels[i]);
      settle();

      // zero width and height act as one, zero tile size: every word is a frame
      write_config(11'd0, 11'd0, 8'd0);
      send_pixel(PX_SOLID);
      send_pixel(PX_ITEM);
      send_pixel(PX_EMPTY);
      settle();

      // oversized width clamps to the maximum, single row
      write_config(11'h7FF, 11'd1, 8'd255);
      send_pixel(PX_SOLID);
      send_pixel(PX_SOLID);
      settle();

      // oversized height clamps to the maximum
      write_config(11'd2, 11'h7FF, 8'd255);
      send_pixel(PX_SOLID);
      send_pixel(PX_HIGH);
      send_pixel(PX_SOLID);
      settle();

      // random frames, mostly whole ones, some cut short by the next setting
      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin w_set = 0; h_set = $urandom_range(1, 6); end
            1: begin w_set = ($urandom_range(0, 1) != 0) ? 2047 : 1024; h_set = 1; end
            2: begin w_set = 1023; h_set = 1; end
            3: begin w_set = $urandom_range(1, 8); h_set = 0; end
            4: begin w_set = $urandom_range(1, 4); h_set = 2047; end
            default: begin w_set = $urandom_range(1, 12); h_set = $urandom_range(1, 8); end
         endcase
         case ($urandom_range(0, 5))
            0: ts_set = 0;
            1: ts_set = 255;
            2: ts_set = 1;
            default: ts_set = $urandom_range(0, 255);
         endcase
         idle_send = ($urandom_range(0, 3) != 0);
         idle_recv = ($urandom_range(0, 3) != 0);
         solid_pct = $urandom_range(30, 80);

         // one phase backs up the output while input keeps coming
         if (phase == 1) begin
            w_set = 8;
            h_set = 6;
            idle_send = 1'b0;
         end

         frame = sb.clamp_dim(w_set, MAX_WIDTH) * sb.clamp_dim(h_set, MAX_HEIGHT);
         if (frame <= 60)
            items = frame * ((frame < 20) ? $urandom_range(2, 3) : 1);
         else
            items = $urandom_range(24, 48);

         write_config(11'(w_set), 11'(h_set), 8'(ts_set));
         if (phase == 1) hold_request = 1'b1;
         for (int i = 0; i < items; i++) send_pixel(random_pixel(solid_pct));
         random_count += items;
         settle();
         phase++;
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected words never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
